FILE: hdl/ring_mask_alpha_blend_assert.svh
// assertion macros used by the checker file
`ifndef RING_MASK_ALPHA_BLEND_ASSERT_SVH
`define RING_MASK_ALPHA_BLEND_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RMAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rmab assertion failed");

// next-cycle implication, disabled during reset
`define RMAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rmab assertion failed");

`endif

FILE: hdl/rmab_pkg.sv
// shared types and constants of the ring mask alpha blend block
package rmab_pkg;

  localparam int PosW     = 12;
  localparam int ChanW    = 8;
  localparam int CoordW   = 14;
  localparam int LimitW   = 30;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 30;
  localparam int DiffW    = 15;
  localparam int SqW      = 28;
  localparam int DistW    = 29;
  localparam int ProdW    = 16;
  localparam int BoundW   = 15;

  localparam int unsigned MaxDim = 4096;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  localparam logic [ChanW-1:0]         RstColorRed   = 8'd200;
  localparam logic [ChanW-1:0]         RstColorGreen = 8'd100;
  localparam logic [ChanW-1:0]         RstColorBlue  = 8'd0;
  localparam logic [ChanW-1:0]         RstColorAlpha = 8'd255;
  localparam logic signed [CoordW-1:0] RstCenterX    = 14'sd128;
  localparam logic signed [CoordW-1:0] RstCenterY    = 14'sd128;
  localparam logic [LimitW-1:0]        RstInnerSq    = 30'd0;
  localparam logic [LimitW-1:0]        RstOuterSq    = 30'd10485;

  typedef enum logic [CfgIdxW-1:0] {
    CfgColorRed   = 3'd0,
    CfgColorGreen = 3'd1,
    CfgColorBlue  = 3'd2,
    CfgColorAlpha = 3'd3,
    CfgCenterX    = 3'd4,
    CfgCenterY    = 3'd5,
    CfgInnerSq    = 3'd6,
    CfgOuterSq    = 3'd7
  } cfg_reg_e;

  // per-stage load strobes
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } pipe_ctrl_t;

endpackage

FILE: hdl/rmab_ifs.sv
// pixel request and result channel interfaces
interface rmab_pix_in_if;
  import rmab_pkg::*;
  logic             valid;
  logic             ready;
  logic [PosW-1:0]  pos_x;
  logic [PosW-1:0]  pos_y;
  logic [ChanW-1:0] canvas_red;
  logic [ChanW-1:0] canvas_green;
  logic [ChanW-1:0] canvas_blue;
  logic [ChanW-1:0] canvas_alpha;

  modport source (
    output valid, pos_x, pos_y, canvas_red, canvas_green, canvas_blue, canvas_alpha,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, canvas_red, canvas_green, canvas_blue, canvas_alpha,
    output ready
  );
endinterface

interface rmab_pix_out_if;
  import rmab_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic [ChanW-1:0] out_alpha;
  logic             in_ring;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, in_ring,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, in_ring,
    output ready
  );
endinterface

FILE: hdl/rmab_pipe_ctrl.sv
// valid bits and stall handling of the three-stage pipeline
module rmab_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmab_pkg::pipe_ctrl_t ctrl_o
);
  import rmab_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  logic rdy1, rdy2, rdy3;
  pipe_ctrl_t ctrl;

  always_comb begin
    rdy3       = !v3_q || out_ready_i;
    rdy2       = !v2_q || rdy3;
    rdy1       = !v1_q || rdy2;
    ctrl.adv3  = v2_q && rdy3;
    ctrl.adv2  = v1_q && rdy2;
    ctrl.adv1  = in_valid_i && rdy1;
    v1_d       = ctrl.adv1 || (v1_q && !ctrl.adv2);
    v2_d       = ctrl.adv2 || (v2_q && !ctrl.adv3);
    v3_d       = ctrl.adv3 || (v3_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;
  assign ctrl_o      = ctrl;
endmodule

FILE: hdl/rmab_dist.sv
// squared distance and ring test, three stages
module rmab_dist (
  input  logic                               clk_i,
  input  rmab_pkg::pipe_ctrl_t               ctrl_i,
  input  logic [rmab_pkg::PosW-1:0]          pos_x_i,
  input  logic [rmab_pkg::PosW-1:0]          pos_y_i,
  input  logic signed [rmab_pkg::CoordW-1:0] center_x_i,
  input  logic signed [rmab_pkg::CoordW-1:0] center_y_i,
  input  logic [rmab_pkg::LimitW-1:0]        inner_sq_i,
  input  logic [rmab_pkg::LimitW-1:0]        outer_sq_i,
  output logic                               paint_o,
  output logic                               in_ring_o
);
  import rmab_pkg::*;

  logic signed [DiffW-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic                      inb_d, inb1_q, inb2_q;
  logic signed [2*DiffW-1:0] sqx, sqy;
  logic [SqW-1:0]            sqx_q, sqy_q;
  logic [DistW-1:0]          dist_sq;
  logic [LimitW-1:0]         dist_ext;
  logic                      paint;
  logic                      ring_q;

  // stage 1: offsets from the centre and the canvas bound
  always_comb begin
    dx_d  = DiffW'(center_x_i) - $signed({(DiffW-PosW)'(0), pos_x_i});
    dy_d  = DiffW'(center_y_i) - $signed({(DiffW-PosW)'(0), pos_y_i});
    inb_d = (BoundW'(pos_x_i) < BoundW'(MaxDim)) && (BoundW'(pos_y_i) < BoundW'(MaxDim));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      inb1_q <= inb_d;
    end
  end

  // stage 2: squares, always below 2^28
  assign sqx = (2*DiffW)'(dx_q) * (2*DiffW)'(dx_q);
  assign sqy = (2*DiffW)'(dy_q) * (2*DiffW)'(dy_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv2) begin
      sqx_q  <= sqx[SqW-1:0];
      sqy_q  <= sqy[SqW-1:0];
      inb2_q <= inb1_q;
    end
  end

  // stage 3: sum and both inclusive limits
  always_comb begin
    dist_sq  = DistW'(sqx_q) + DistW'(sqy_q);
    dist_ext = LimitW'(dist_sq);
    paint    = inb2_q && (dist_ext >= inner_sq_i) && (dist_ext <= outer_sq_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv3) begin
      ring_q <= paint;
    end
  end

  assign paint_o   = paint;
  assign in_ring_o = ring_q;
endmodule

FILE: hdl/rmab_mix.sv
// one channel of the blend (a*c + (255-a)*d)/255, three stages
module rmab_mix (
  input  logic                        clk_i,
  input  rmab_pkg::pipe_ctrl_t        ctrl_i,
  input  logic [rmab_pkg::ChanW-1:0]  alpha_i,
  input  logic [rmab_pkg::ChanW-1:0]  color_i,
  input  logic [rmab_pkg::ChanW-1:0]  canvas_i,
  input  logic                        paint_i,
  output logic [rmab_pkg::ChanW-1:0]  chan_o
);
  import rmab_pkg::*;

  logic [ProdW-1:0] prod_ac_q, prod_bd_q, sum_q;
  logic [ChanW-1:0] d1_q, d2_q, out_q;
  logic [ProdW:0]   quo_t;
  logic [ChanW-1:0] quo;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      prod_ac_q <= ProdW'(alpha_i) * ProdW'(color_i);
      prod_bd_q <= ProdW'(ChanMax - alpha_i) * ProdW'(canvas_i);
      d1_q      <= canvas_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv2) begin
      sum_q <= prod_ac_q + prod_bd_q;
      d2_q  <= d1_q;
    end
  end

  // exact divide by 255 for sums up to 255*255
  always_comb begin
    quo_t = {1'b0, sum_q} + (ProdW+1)'(1) + (ProdW+1)'(sum_q[ProdW-1:ChanW]);
    quo   = quo_t[ProdW-1:ChanW];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv3) begin
      out_q <= paint_i ? quo : d2_q;
    end
  end

  assign chan_o = out_q;
endmodule

FILE: hdl/ring_mask_alpha_blend.sv
// Ring mask with alpha blend, top level.
// Pixel requests arrive on pix_i (valid/ready): column, row and the RGBA of
// the canvas beneath. Results leave on pix_o (valid/ready): the RGBA pixel
// and in_ring. A pixel whose squared distance to the centre lies within the
// inclusive squared limits, and whose position is inside the canvas, gets the
// ring colour blended over the canvas; any other pixel passes unchanged.
// The user must write registers through cfg_we_i / cfg_idx_i / cfg_data_i
// only while the pipeline is empty; the block does not enforce this.
// One request per cycle is sustained while pix_o.ready stays high; the three
// register stages are offset, square, and sum/compare/divide, each with its
// own valid bit.
// Reset empties the pipeline and loads the register defaults.
// When the receiver stalls, the result stays on pix_o and the earlier stages
// keep filling; pix_i.ready falls only once every stage holds a request.
module ring_mask_alpha_blend (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rmab_pix_in_if.sink                      pix_i,
  rmab_pix_out_if.source                   pix_o,
  input  logic                             cfg_we_i,
  input  logic [rmab_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rmab_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rmab_pkg::*;

  logic [ChanW-1:0]         color_red_q, color_green_q, color_blue_q, color_alpha_q;
  logic signed [CoordW-1:0] center_x_q, center_y_q;
  logic [LimitW-1:0]        inner_sq_q, outer_sq_q;
  pipe_ctrl_t               ctrl;
  logic                     paint;
  logic                     in_ready;
  logic                     out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_red_q   <= RstColorRed;
      color_green_q <= RstColorGreen;
      color_blue_q  <= RstColorBlue;
      color_alpha_q <= RstColorAlpha;
      center_x_q    <= RstCenterX;
      center_y_q    <= RstCenterY;
      inner_sq_q    <= RstInnerSq;
      outer_sq_q    <= RstOuterSq;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgColorRed: begin
          color_red_q <= cfg_data_i[ChanW-1:0];
        end
        CfgColorGreen: begin
          color_green_q <= cfg_data_i[ChanW-1:0];
        end
        CfgColorBlue: begin
          color_blue_q <= cfg_data_i[ChanW-1:0];
        end
        CfgColorAlpha: begin
          color_alpha_q <= cfg_data_i[ChanW-1:0];
        end
        CfgCenterX: begin
          center_x_q <= $signed(cfg_data_i[CoordW-1:0]);
        end
        CfgCenterY: begin
          center_y_q <= $signed(cfg_data_i[CoordW-1:0]);
        end
        CfgInnerSq: begin
          inner_sq_q <= cfg_data_i[LimitW-1:0];
        end
        CfgOuterSq: begin
          outer_sq_q <= cfg_data_i[LimitW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  rmab_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (pix_o.ready),
    .ctrl_o      (ctrl)
  );

  assign pix_i.ready = in_ready;
  assign pix_o.valid = out_valid;

  rmab_dist u_dist (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .pos_x_i    (pix_i.pos_x),
    .pos_y_i    (pix_i.pos_y),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .inner_sq_i (inner_sq_q),
    .outer_sq_i (outer_sq_q),
    .paint_o    (paint),
    .in_ring_o  (pix_o.in_ring)
  );

  rmab_mix u_mix_red (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .alpha_i  (color_alpha_q),
    .color_i  (color_red_q),
    .canvas_i (pix_i.canvas_red),
    .paint_i  (paint),
    .chan_o   (pix_o.out_red)
  );

  rmab_mix u_mix_green (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .alpha_i  (color_alpha_q),
    .color_i  (color_green_q),
    .canvas_i (pix_i.canvas_green),
    .paint_i  (paint),
    .chan_o   (pix_o.out_green)
  );

  rmab_mix u_mix_blue (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .alpha_i  (color_alpha_q),
    .color_i  (color_blue_q),
    .canvas_i (pix_i.canvas_blue),
    .paint_i  (paint),
    .chan_o   (pix_o.out_blue)
  );

  // a + (255-a)*da/255 equals (255*a + (255-a)*da)/255
  rmab_mix u_mix_alpha (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .alpha_i  (color_alpha_q),
    .color_i  (ChanMax),
    .canvas_i (pix_i.canvas_alpha),
    .paint_i  (paint),
    .chan_o   (pix_o.out_alpha)
  );
endmodule

FILE: hdl/rmab_checker.sv
// port-level checker for the ring mask alpha blend block, with its bind
module rmab_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [rmab_pkg::ChanW-1:0]   out_red_i,
  input logic [rmab_pkg::ChanW-1:0]   out_green_i,
  input logic [rmab_pkg::ChanW-1:0]   out_blue_i,
  input logic [rmab_pkg::ChanW-1:0]   out_alpha_i,
  input logic                         in_ring_i
);
`include "ring_mask_alpha_blend_assert.svh"

  // result held while stalled
  `RMAB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RMAB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_red_i) && $stable(out_green_i) && $stable(out_blue_i) && $stable(out_alpha_i) && $stable(in_ring_i))
  // an open output never backs up the input side
  `RMAB_ASSERT_NOW(a_ready_flow, clk_i, rst_ni, out_ready_i, in_ready_i)
  // an accepted request comes out valid when the output does not stall
  `RMAB_ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i, out_valid_i)
endmodule

bind ring_mask_alpha_blend rmab_checker u_rmab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_red_i   (pix_o.out_red),
  .out_green_i (pix_o.out_green),
  .out_blue_i  (pix_o.out_blue),
  .out_alpha_i (pix_o.out_alpha),
  .in_ring_i   (pix_o.in_ring)
);

FILE: sim/ring_mask_alpha_blend_tb.sv
// testbench for ring_mask_alpha_blend: directed and random pixels checked against a ring blend predictor
`timescale 1ns / 1ps

module ring_mask_alpha_blend_tb;
  import rmab_pkg::*;

  localparam int HoldCycles  = 120;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 10;
  localparam int RandPhases  = 10;
  localparam int PhaseItems  = 65;
  localparam int unsigned Full = ChanMax;

  typedef struct packed {
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pixel_req_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             in_ring;
  } pixel_res_t;

  typedef struct packed {
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [ChanW-1:0]  alpha;
    logic [CoordW-1:0] ctr_x;
    logic [CoordW-1:0] ctr_y;
    logic [LimitW-1:0] inner_sq;
    logic [LimitW-1:0] outer_sq;
  } ring_cfg_t;

  class ring_blend_scoreboard;
    ring_cfg_t  ring;
    pixel_res_t expected_pixels[$];
    int         errors;

    function new();
      ring.red      = RstColorRed;
      ring.green    = RstColorGreen;
      ring.blue     = RstColorBlue;
      ring.alpha    = RstColorAlpha;
      ring.ctr_x    = RstCenterX;
      ring.ctr_y    = RstCenterY;
      ring.inner_sq = RstInnerSq;
      ring.outer_sq = RstOuterSq;
      errors        = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgColorRed:   ring.red      = data[ChanW-1:0];
        CfgColorGreen: ring.green    = data[ChanW-1:0];
        CfgColorBlue:  ring.blue     = data[ChanW-1:0];
        CfgColorAlpha: ring.alpha    = data[ChanW-1:0];
        CfgCenterX:    ring.ctr_x    = data[CoordW-1:0];
        CfgCenterY:    ring.ctr_y    = data[CoordW-1:0];
        CfgInnerSq:    ring.inner_sq = data[LimitW-1:0];
        CfgOuterSq:    ring.outer_sq = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ChanW-1:0] mix(int unsigned a, int unsigned c, int unsigned d);
      return ChanW'((a * c + (Full - a) * d) / Full);
    endfunction

    function pixel_res_t blend_pixel(pixel_req_t p);
      longint      dx;
      longint      dy;
      longint      dist_sq;
      int unsigned a;
      pixel_res_t  r;
      dx      = longint'($signed(ring.ctr_x)) - longint'(p.pos_x);
      dy      = longint'($signed(ring.ctr_y)) - longint'(p.pos_y);
      dist_sq = dx * dx + dy * dy;
      a       = ring.alpha;
      if (p.pos_x < MaxDim && p.pos_y < MaxDim &&
          dist_sq >= longint'(ring.inner_sq) && dist_sq <= longint'(ring.outer_sq)) begin
        r.red     = mix(a, ring.red, p.red);
        r.green   = mix(a, ring.green, p.green);
        r.blue    = mix(a, ring.blue, p.blue);
        r.alpha   = ChanW'(a + ((Full - a) * p.alpha) / Full);
        r.in_ring = 1'b1;
      end else begin
        r.red     = p.red;
        r.green   = p.green;
        r.blue    = p.blue;
        r.alpha   = p.alpha;
        r.in_ring = 1'b0;
      end
      return r;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("%0t mismatch: %s", $time, msg);
    endtask

    task note_request(pixel_req_t p);
      expected_pixels.push_back(blend_pixel(p));
    endtask

    task check_result(pixel_res_t got);
      pixel_res_t want;
      if (expected_pixels.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red)
          report($sformatf("out_red got %0d expected %0d", got.red, want.red));
        if (got.green !== want.green)
          report($sformatf("out_green got %0d expected %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report($sformatf("out_blue got %0d expected %0d", got.blue, want.blue));
        if (got.alpha !== want.alpha)
          report($sformatf("out_alpha got %0d expected %0d", got.alpha, want.alpha));
        if (got.in_ring !== want.in_ring)
          report($sformatf("in_ring got %0b expected %0b", got.in_ring, want.in_ring));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rmab_pix_in_if  pix_in ();
  rmab_pix_out_if pix_out ();

  ring_blend_scoreboard sb;
  bit        steady;
  bit        hold_off_req;
  int        reach;
  ring_cfg_t cur_ring;
  int        quiet_cycles = 0;

  ring_mask_alpha_blend DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_in),
    .pix_o      (pix_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic pixel_req_t pixel_at(int x, int y, logic [ChanW-1:0] r,
                                          logic [ChanW-1:0] g, logic [ChanW-1:0] b,
                                          logic [ChanW-1:0] a);
    pixel_req_t p;
    p.pos_x = PosW'(x);
    p.pos_y = PosW'(y);
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  function automatic ring_cfg_t ring_setting(int r, int g, int b, int a, int cx, int cy,
                                             logic [LimitW-1:0] inner,
                                             logic [LimitW-1:0] outer);
    ring_cfg_t c;
    c.red      = ChanW'(r);
    c.green    = ChanW'(g);
    c.blue     = ChanW'(b);
    c.alpha    = ChanW'(a);
    c.ctr_x    = CoordW'(cx);
    c.ctr_y    = CoordW'(cy);
    c.inner_sq = inner;
    c.outer_sq = outer;
    return c;
  endfunction

  function automatic ring_cfg_t random_ring();
    ring_cfg_t c;
    int        r_in;
    int        r_out;
    c.red   = ChanW'($urandom);
    c.green = ChanW'($urandom);
    c.blue  = ChanW'($urandom);
    case ($urandom_range(0, 3))
      0:       c.alpha = '0;
      1:       c.alpha = ChanMax;
      default: c.alpha = ChanW'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      c.ctr_x = CoordW'($urandom);
      c.ctr_y = CoordW'($urandom);
    end else begin
      c.ctr_x = CoordW'(int'($urandom_range(0, 4400)) - 150);
      c.ctr_y = CoordW'(int'($urandom_range(0, 4400)) - 150);
    end
    r_in       = $urandom_range(0, 400);
    r_out      = r_in + $urandom_range(0, 400);
    c.inner_sq = LimitW'(r_in * r_in);
    c.outer_sq = LimitW'(r_out * r_out);
    case ($urandom_range(0, 9))
      0: c.inner_sq = c.outer_sq + 1'b1;  // empty ring
      1: begin
        c.inner_sq = LimitW'($urandom);
        c.outer_sq = LimitW'($urandom);
      end
      2: c.outer_sq = '1;
      default: ;
    endcase
    reach = r_out + 8;
    return c;
  endfunction

  // most pixels land in a square around the ring, the rest anywhere
  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    int         x;
    int         y;
    if ($urandom_range(0, 9) < 7) begin
      x = int'($signed(cur_ring.ctr_x)) + int'($urandom_range(0, 2 * reach)) - reach;
      y = int'($signed(cur_ring.ctr_y)) + int'($urandom_range(0, 2 * reach)) - reach;
      p.pos_x = PosW'((x < 0) ? 0 : (x > int'(MaxDim) - 1) ? int'(MaxDim) - 1 : x);
      p.pos_y = PosW'((y < 0) ? 0 : (y > int'(MaxDim) - 1) ? int'(MaxDim) - 1 : y);
    end else begin
      p.pos_x = PosW'($urandom);
      p.pos_y = PosW'($urandom);
    end
    case ($urandom_range(0, 7))
      0:       {p.red, p.green, p.blue, p.alpha} = '0;
      1:       {p.red, p.green, p.blue, p.alpha} = '1;
      default: {p.red, p.green, p.blue, p.alpha} = $urandom;
    endcase
    return p;
  endfunction

  // valid stays high from one request to the next unless a gap is picked
  task automatic send_pixel(pixel_req_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid        <= 1'b1;
    pix_in.pos_x        <= p.pos_x;
    pix_in.pos_y        <= p.pos_y;
    pix_in.canvas_red   <= p.red;
    pix_in.canvas_green <= p.green;
    pix_in.canvas_blue  <= p.blue;
    pix_in.canvas_alpha <= p.alpha;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic program_ring(ring_cfg_t c);
    pix_in.valid <= 1'b0;
    // let the scoreboard note the last accepted request before the queue is checked
    @(posedge clk_i);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    write_reg(CfgColorRed,   {(CfgDataW-ChanW)'($urandom), c.red});
    write_reg(CfgColorGreen, {(CfgDataW-ChanW)'($urandom), c.green});
    write_reg(CfgColorBlue,  {(CfgDataW-ChanW)'($urandom), c.blue});
    write_reg(CfgColorAlpha, {(CfgDataW-ChanW)'($urandom), c.alpha});
    write_reg(CfgCenterX,    {(CfgDataW-CoordW)'($urandom), c.ctr_x});
    write_reg(CfgCenterY,    {(CfgDataW-CoordW)'($urandom), c.ctr_y});
    write_reg(CfgInnerSq,    c.inner_sq);
    write_reg(CfgOuterSq,    c.outer_sq);
    cfg_we_i <= 1'b0;
    cur_ring = c;
  endtask

  // result side: random stalls, plus one long hold-off on demand
  initial begin
    int stall;
    pix_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HoldCycles;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        pix_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pix_out.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_in.valid && pix_in.ready)
        sb.note_request(pixel_req_t'({pix_in.pos_x, pix_in.pos_y, pix_in.canvas_red,
                                      pix_in.canvas_green, pix_in.canvas_blue,
                                      pix_in.canvas_alpha}));
      if (pix_out.valid && pix_out.ready)
        sb.check_result(pixel_res_t'({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                                      pix_out.out_alpha, pix_out.in_ring}));
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("[ring_mask_alpha_blend] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    sb = new();
    steady       = 1'b0;
    hold_off_req = 1'b0;
    reach        = 16;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CfgColorRed;
    cfg_data_i          <= '0;
    pix_in.valid        <= 1'b0;
    pix_in.pos_x        <= '0;
    pix_in.pos_y        <= '0;
    pix_in.canvas_red   <= '0;
    pix_in.canvas_green <= '0;
    pix_in.canvas_blue  <= '0;
    pix_in.canvas_alpha <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: centre sits on the inner limit, 102^2 + 9^2 hits the outer one
    send_pixel(pixel_at(128, 128, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pixel_at(26, 119, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(pixel_at(26, 118, 8'h12, 8'h34, 8'h56, 8'h78));
    send_pixel(pixel_at(0, 0, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(pixel_at(4095, 4095, 8'ha5, 8'h5a, 8'h3c, 8'hc3));

    // transparent colour, centre at the far corners, widest limits
    program_ring(ring_setting(255, 255, 255, 0, 8191, -8192, '0, '1));
    send_pixel(pixel_at(0, 0, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(pixel_at(4095, 4095, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pixel_at(4095, 0, 8'h0c, 8'h22, 8'h38, 8'h4e));

    // zero-width ring through exactly one far pixel
    program_ring(ring_setting(0, 255, 17, 128, -8192, 8191, 30'd83886080, 30'd83886080));
    send_pixel(pixel_at(0, 4095, 8'h80, 8'h80, 8'h80, 8'h80));
    send_pixel(pixel_at(1, 4095, 8'h80, 8'h80, 8'h80, 8'h80));
    send_pixel(pixel_at(0, 4094, 8'h80, 8'h80, 8'h80, 8'h80));

    // inner limit above outer limit paints nothing
    program_ring(ring_setting(10, 20, 30, 200, 100, 100, 30'd1000, 30'd999));
    send_pixel(pixel_at(100, 100, 8'h33, 8'h44, 8'h55, 8'h66));
    send_pixel(pixel_at(131, 100, 8'h33, 8'h44, 8'h55, 8'h66));
    send_pixel(pixel_at(100, 132, 8'h33, 8'h44, 8'h55, 8'h66));

    // nearly transparent colour over a full canvas
    program_ring(ring_setting(1, 2, 3, 1, 2048, 2048, '0, '0));
    send_pixel(pixel_at(2048, 2048, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(pixel_at(2049, 2048, 8'hff, 8'hff, 8'hff, 8'hff));

    for (int ph = 0; ph < RandPhases; ph++) begin
      program_ring(random_ring());
      steady       = (ph == 3) || (ph == 6);
      hold_off_req = (ph == 6);
      repeat (PhaseItems) send_pixel(random_pixel());
      steady = 1'b0;
    end

    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ring_mask_alpha_blend] OK");
    end else begin
      $display("[ring_mask_alpha_blend] ERROR");
    end
    $finish;
  end

endmodule
